// ----- rtl/zsr_pkg.sv -----
// ----------------------------------------------------------------------------
// zsr_pkg
// Types and constants shared by the Zernike subpixel edge refinement core.
// ----------------------------------------------------------------------------
`default_nettype none

package zsr_pkg;

    localparam int WINDOW_SIZE_DEF = 7;
    localparam int N_PIX    = 7;
    localparam int W_CXY    = 12;
    localparam int W_PIX    = 8;
    localparam int W_MAB    = 16;
    localparam int W_MC     = 18;
    localparam int W_DIM    = 13;
    localparam int W_THR    = 16;
    localparam int W_LIM    = 11;
    localparam int W_CFG    = 16;
    localparam int W_CFGIDX = 2;
    localparam int W_SUB    = 20;
    localparam int W_ROW    = 3;

    localparam logic [W_DIM-1:0] WIDTH_RST  = 13'd640;
    localparam logic [W_DIM-1:0] HEIGHT_RST = 13'd480;
    localparam logic [W_THR-1:0] THR_RST    = 16'd10;
    localparam logic [W_LIM-1:0] LIMIT_RST  = 11'd410;

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_BORDER = 2'd1,
        ST_WEAK   = 2'd2,
        ST_FAR    = 2'd3
    } t_status;

    typedef enum logic [W_CFGIDX-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_THR    = 2'd2,
        CFG_LIMIT  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [W_CXY-1:0] center_x;
        logic [W_CXY-1:0] center_y;
        logic [W_PIX-1:0] pixel_0;
        logic [W_PIX-1:0] pixel_1;
        logic [W_PIX-1:0] pixel_2;
        logic [W_PIX-1:0] pixel_3;
        logic [W_PIX-1:0] pixel_4;
        logic [W_PIX-1:0] pixel_5;
        logic [W_PIX-1:0] pixel_6;
        logic             last_row;
    } t_in_req;

    typedef struct packed {
        t_status          status;
        logic [W_SUB-1:0] sub_x;
        logic [W_SUB-1:0] sub_y;
    } t_out_req;

    typedef struct packed {
        logic signed [W_MAB-1:0] a;
        logic signed [W_MAB-1:0] b;
        logic signed [W_MC-1:0]  c;
        logic [W_CXY-1:0]        cx;
        logic [W_CXY-1:0]        cy;
    } t_moments;

    typedef struct packed {
        logic [W_DIM-1:0] width;
        logic [W_DIM-1:0] height;
        logic [W_THR-1:0] thr;
        logic [W_LIM-1:0] limit;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/zsr_lane.sv -----
// ----------------------------------------------------------------------------
// zsr_lane
// Moment contributions of one window column for the current row.
// ----------------------------------------------------------------------------
`default_nettype none

module zsr_lane
    import zsr_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    parameter int COL         = 0
) (
    input  wire logic [W_PIX-1:0]      i_pix,
    input  wire logic [W_ROW-1:0]      i_row,
    output logic signed [W_MC-1:0]     o_ca,
    output logic signed [W_MC-1:0]     o_cb,
    output logic signed [W_MC-1:0]     o_cc
);

    localparam int H = WINDOW_SIZE / 2;
    localparam logic signed [4:0] DX  = 5'(COL - H);
    localparam logic signed [9:0] HSQ = 10'(H * H);
    localparam logic signed [9:0] DX2 = 10'((COL - H) * (COL - H));

    logic signed [4:0]  dy;
    logic signed [9:0]  r2;
    logic signed [9:0]  coef;
    logic signed [9:0]  g;
    logic               in_disc;

    always_comb begin
        dy      = signed'({2'b00, i_row}) - 5'(H);
        r2      = DX2 + 10'(dy * dy);
        coef    = 10'(r2 * 2) - HSQ;
        g       = signed'({2'b00, i_pix});
        in_disc = (r2 <= HSQ) && ({1'b0, i_row} < 4'(WINDOW_SIZE));
        o_ca    = in_disc ? W_MC'(g * DX) : '0;
        o_cb    = in_disc ? W_MC'(g * (-dy)) : '0;
        o_cc    = in_disc ? W_MC'(g * coef) : '0;
    end

endmodule

`default_nettype wire

// ----- rtl/zsr_accum.sv -----
// ----------------------------------------------------------------------------
// zsr_accum
// Parallel column lanes, merge adder and the running window moments.
// ----------------------------------------------------------------------------
`default_nettype none

module zsr_accum
    import zsr_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_acc,
    input  wire t_in_req i_req,
    output t_moments o_mom
);

    logic [W_PIX-1:0]       pix [N_PIX];
    logic signed [W_MC-1:0] ca  [N_PIX];
    logic signed [W_MC-1:0] cb  [N_PIX];
    logic signed [W_MC-1:0] cc  [N_PIX];
    logic signed [W_MAB-1:0] r_a, n_a;
    logic signed [W_MAB-1:0] r_b, n_b;
    logic signed [W_MC-1:0]  r_c, n_c;
    logic [W_ROW-1:0]        r_row;
    logic signed [W_MC-1:0]  sa, sb, sc;

    always_comb begin
        pix[0] = i_req.pixel_0;
        pix[1] = i_req.pixel_1;
        pix[2] = i_req.pixel_2;
        pix[3] = i_req.pixel_3;
        pix[4] = i_req.pixel_4;
        pix[5] = i_req.pixel_5;
        pix[6] = i_req.pixel_6;
    end

    for (genvar j = 0; j < N_PIX; j++) begin : g_lane
        if (j < WINDOW_SIZE) begin : g_on
            zsr_lane #(
                .WINDOW_SIZE (WINDOW_SIZE),
                .COL         (j)
            ) u_lane (
                .i_pix (pix[j]),
                .i_row (r_row),
                .o_ca  (ca[j]),
                .o_cb  (cb[j]),
                .o_cc  (cc[j])
            );
        end else begin : g_off
            assign ca[j] = '0;
            assign cb[j] = '0;
            assign cc[j] = '0;
        end
    end

    // merge the lanes into the running moments
    always_comb begin
        sa = W_MC'(r_a);
        sb = W_MC'(r_b);
        sc = r_c;
        for (int j = 0; j < N_PIX; j++) begin
            sa = sa + ca[j];
            sb = sb + cb[j];
            sc = sc + cc[j];
        end
        n_a = sa[W_MAB-1:0];
        n_b = sb[W_MAB-1:0];
        n_c = sc;
        o_mom.a  = n_a;
        o_mom.b  = n_b;
        o_mom.c  = n_c;
        o_mom.cx = i_req.center_x;
        o_mom.cy = i_req.center_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a   <= '0;
            r_b   <= '0;
            r_c   <= '0;
            r_row <= '0;
        end else if (i_acc) begin
            if (i_req.last_row) begin
                r_a   <= '0;
                r_b   <= '0;
                r_c   <= '0;
                r_row <= '0;
            end else begin
                r_a <= n_a;
                r_b <= n_b;
                r_c <= n_c;
                if (r_row != '1) begin
                    r_row <= r_row + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/zsr_mul.sv -----
// ----------------------------------------------------------------------------
// zsr_mul
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module zsr_mul
    import zsr_pkg::*;
#(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_x,
    input  wire logic [W-1:0] i_y,
    output logic              o_done,
    output logic [2*W-1:0]    o_prod
);

    logic [2*W-1:0]       r_acc;
    logic [2*W-1:0]       r_mc;
    logic [W-1:0]         r_mp;
    logic [$clog2(W)-1:0] r_cnt;
    logic                 r_run;
    logic                 r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc <= '0;
                r_mc  <= {{W{1'b0}}, i_x};
                r_mp  <= i_y;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                if (r_mp[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc  <= r_mc << 1;
                r_mp  <= r_mp >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == $clog2(W)'(W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

// ----- rtl/zsr_div.sv -----
// ----------------------------------------------------------------------------
// zsr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module zsr_div
    import zsr_pkg::*;
#(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_num,
    input  wire logic [W-1:0] i_den,
    output logic              o_done,
    output logic [W-1:0]      o_quo
);

    logic [W:0]           r_rem;
    logic [W-1:0]         r_num;
    logic [W-1:0]         r_den;
    logic [W-1:0]         r_quo;
    logic [$clog2(W)-1:0] r_cnt;
    logic                 r_run;
    logic                 r_done;
    logic [W:0]           trial;
    logic                 ge;

    always_comb begin
        trial = {r_rem[W-1:0], r_num[W-1]};
        ge    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem <= '0;
                r_num <= i_num;
                r_den <= i_den;
                r_quo <= '0;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_rem <= ge ? trial - {1'b0, r_den} : trial;
                r_quo <= {r_quo[W-2:0], ge};
                r_num <= r_num << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == $clog2(W)'(W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ----- rtl/zsr_final.sv -----
// ----------------------------------------------------------------------------
// zsr_final
// Per-window checks, exact distance test and subpixel offset, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module zsr_final
    import zsr_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_moments i_mom,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_out_stall,
    output logic          o_busy,
    output logic          o_out_valid,
    output t_out_req      o_out
);

    localparam int H   = WINDOW_SIZE / 2;
    localparam int HSQ = H * H;
    localparam logic signed [14:0] H15 = 15'(H);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SUM, S_CHK, S_P1, S_P2, S_P3,
        S_LHS, S_RHS, S_MA, S_DA, S_MB, S_DB, S_PLACE, S_OUT
    } t_state;

    t_state                  r_state;
    logic signed [W_MAB-1:0] r_a, r_b;
    logic signed [W_MC-1:0]  r_c;
    logic [W_CXY-1:0]        r_cx, r_cy;
    logic                    r_border;
    logic [31:0]             r_a2, r_b2, r_t2, r_s;
    logic signed [31:0]      r_d;
    logic [35:0]             r_tq;
    logic [63:0]             r_cd, r_s2, r_slh, r_m, r_qa, r_qb;
    logic [127:0]            r_lhs;
    logic [13:0]             r_lh;
    logic [27:0]             r_lh2;
    logic                    r_cdneg;
    t_status                 r_status;
    logic [W_SUB-1:0]        r_sx, r_sy;
    logic                    r_mul_start, r_div_start;
    logic                    r_out_valid;
    t_out_req                r_out;

    logic [W_MC-1:0]  magc;
    logic [31:0]      magd;
    logic [W_MAB-1:0] maga, magb;
    logic [63:0]      mul_x, mul_y;
    logic             mul_done, div_done;
    logic [127:0]     mul_p;
    logic [63:0]      div_q;
    logic             border_in;
    logic signed [14:0] cxs, cys, wlim, hlim;

    function automatic logic [W_SUB-1:0] place_q8(input logic [W_CXY-1:0] cx,
                                                  input logic [63:0] q,
                                                  input logic neg);
        logic [W_SUB-1:0] base;
        logic [W_SUB:0]   sum;
        base = {cx, 8'd0};
        sum  = {1'b0, base} + {1'b0, q[W_SUB-1:0]};
        if (!neg) begin
            if ((q[63:W_SUB] != '0) || sum[W_SUB]) begin
                return '1;
            end
            return sum[W_SUB-1:0];
        end
        if (q > {44'd0, base}) begin
            return '0;
        end
        return base - q[W_SUB-1:0];
    endfunction

    always_comb begin
        magc = r_c[W_MC-1] ? W_MC'(-r_c) : W_MC'(r_c);
        magd = r_d[31] ? 32'(-r_d) : 32'(r_d);
        maga = r_a[W_MAB-1] ? W_MAB'(-r_a) : W_MAB'(r_a);
        magb = r_b[W_MAB-1] ? W_MAB'(-r_b) : W_MAB'(r_b);
        cxs  = signed'({3'b000, i_mom.cx});
        cys  = signed'({3'b000, i_mom.cy});
        wlim = signed'({2'b00, i_cfg.width}) - H15;
        hlim = signed'({2'b00, i_cfg.height}) - H15;
        border_in = (cxs < H15) || (cxs >= wlim) || (cys < H15) || (cys >= hlim);
    end

    always_comb begin
        case (r_state)
            S_LHS: begin
                mul_x = r_cd << 10;
                mul_y = r_cd << 10;
            end
            S_RHS: begin
                mul_x = r_s2;
                mul_y = r_slh;
            end
            S_MA: begin
                mul_x = r_cd;
                mul_y = {40'd0, maga, 8'd0};
            end
            S_MB: begin
                mul_x = r_cd;
                mul_y = {40'd0, magb, 8'd0};
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    zsr_mul #(.W(64)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    zsr_div #(.W(64)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_m + (r_s2 >> 1)),
        .i_den   (r_s2),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_a      <= i_mom.a;
                        r_b      <= i_mom.b;
                        r_c      <= i_mom.c;
                        r_cx     <= i_mom.cx;
                        r_cy     <= i_mom.cy;
                        r_border <= border_in;
                        r_sx     <= '0;
                        r_sy     <= '0;
                        r_status <= ST_ACCEPT;
                        r_state  <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_a2    <= 32'(r_a * r_a);
                    r_b2    <= 32'(r_b * r_b);
                    r_t2    <= 32'(i_cfg.thr) * 32'(i_cfg.thr);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_s     <= r_a2 + r_b2;
                    r_d     <= signed'(r_a2) - signed'(r_b2);
                    r_tq    <= 36'(r_t2) * 36'(HSQ);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_border) begin
                        r_status <= ST_BORDER;
                        r_state  <= S_OUT;
                    end else if ({4'd0, r_s} < r_tq) begin
                        r_status <= ST_WEAK;
                        r_state  <= S_OUT;
                    end else if (r_s == '0) begin
                        if (r_c == '0) begin
                            r_sx <= {r_cx, 8'd0};
                            r_sy <= {r_cy, 8'd0};
                        end else begin
                            r_status <= ST_FAR;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_P1;
                    end
                end
                S_P1: begin
                    r_cd    <= 64'(magc * magd);
                    r_s2    <= 64'(r_s) * 64'(r_s);
                    r_lh    <= 14'(i_cfg.limit) * 14'(H);
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_lh2   <= 28'(r_lh) * 28'(r_lh);
                    r_cdneg <= (r_c[W_MC-1] != r_d[31]) && (r_cd != '0);
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_slh       <= 64'(r_s * r_lh2);
                    r_mul_start <= 1'b1;
                    r_state     <= S_LHS;
                end
                S_LHS: begin
                    if (mul_done) begin
                        r_lhs       <= mul_p;
                        r_mul_start <= 1'b1;
                        r_state     <= S_RHS;
                    end
                end
                S_RHS: begin
                    if (mul_done) begin
                        if (r_lhs > mul_p) begin
                            r_status <= ST_FAR;
                            r_state  <= S_OUT;
                        end else begin
                            r_mul_start <= 1'b1;
                            r_state     <= S_MA;
                        end
                    end
                end
                S_MA: begin
                    if (mul_done) begin
                        r_m         <= mul_p[63:0];
                        r_div_start <= 1'b1;
                        r_state     <= S_DA;
                    end
                end
                S_DA: begin
                    if (div_done) begin
                        r_qa        <= div_q;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MB;
                    end
                end
                S_MB: begin
                    if (mul_done) begin
                        r_m         <= mul_p[63:0];
                        r_div_start <= 1'b1;
                        r_state     <= S_DB;
                    end
                end
                S_DB: begin
                    if (div_done) begin
                        r_qb    <= div_q;
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    r_sx    <= place_q8(r_cx, r_qa, r_cdneg != r_a[W_MAB-1]);
                    r_sy    <= place_q8(r_cy, r_qb, r_cdneg != r_b[W_MAB-1]);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out.status <= r_status;
                        r_out.sub_x  <= r_sx;
                        r_out.sub_y  <= r_sy;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ST_ACCEPT)) |->
            ((r_out.sub_x == '0) && (r_out.sub_y == '0)))
        else $error("rejected window carries a position");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("window ended while finalizer busy");

    a_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> ((r_state == S_LHS) || (r_state == S_RHS) ||
                      (r_state == S_MA) || (r_state == S_MB)))
        else $error("multiplier finished outside a multiply step");

    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("output loaded outside the output step");

endmodule

`default_nettype wire

// ----- rtl/zernike_subpixel_edge_refine_core.sv -----
// ----------------------------------------------------------------------------
// zernike_subpixel_edge_refine_core
// Zernike moment subpixel edge refinement over a 7x7 window, one row a request.
// ----------------------------------------------------------------------------
// throughput: one window row per cycle; a last row stalls while the previous
//   window is in the finalizer, also while it waits for the output register
// finalizer: border, weak and zero strength leave at the check step, far
//   after the distance test, accepted after serial multiplies and divides
// reset: synchronous active low; clears moments, row count, finalizer and
//   output valid, loads the default configuration
`default_nettype none

module zernike_subpixel_edge_refine_core
    import zsr_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_in_req             i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_out_req                 o_out,
    input  wire logic                i_cfg_we,
    input  wire logic [W_CFGIDX-1:0] i_cfg_addr,
    input  wire logic [W_CFG-1:0]    i_cfg_wdata
);

    t_cfg     r_cfg;
    t_moments mom;
    logic     fin_busy;
    logic     in_acc;

    assign o_in_stall = fin_busy && i_in.last_row;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= WIDTH_RST;
            r_cfg.height <= HEIGHT_RST;
            r_cfg.thr    <= THR_RST;
            r_cfg.limit  <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_WIDTH:  r_cfg.width  <= i_cfg_wdata[W_DIM-1:0];
                CFG_HEIGHT: r_cfg.height <= i_cfg_wdata[W_DIM-1:0];
                CFG_THR:    r_cfg.thr    <= i_cfg_wdata[W_THR-1:0];
                CFG_LIMIT:  r_cfg.limit  <= i_cfg_wdata[W_LIM-1:0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    zsr_accum #(.WINDOW_SIZE(WINDOW_SIZE)) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (in_acc),
        .i_req   (i_in),
        .o_mom   (mom)
    );

    zsr_final #(.WINDOW_SIZE(WINDOW_SIZE)) u_final (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_acc && i_in.last_row),
        .i_mom       (mom),
        .i_cfg       (r_cfg),
        .i_out_stall (i_out_stall),
        .o_busy      (fin_busy),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
